>>> hdl/ismet_pkg.sv
// shared types and constants for the ising metropolis spin update core
// no dependencies; imported by every module of the core but ismet_ram

package ismet_pkg;

  // default lattice edge length
  localparam int SIDE_DEFAULT = 32;

  // field widths
  localparam int KIND_W   = 1;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 5;
  localparam int RND_W    = 16;
  localparam int THR_W    = 16;
  localparam int DE_W     = 5;
  localparam int MAG_W    = 12;

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TRIAL = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = 1'd1;

  // energy change values
  localparam logic signed [DE_W-1:0] DE_ZERO      = 5'sd0;
  localparam logic signed [DE_W-1:0] DE_FOUR      = 5'sd4;
  localparam logic signed [DE_W-1:0] DE_EIGHT     = 5'sd8;
  localparam logic signed [DE_W-1:0] DE_NEG_FOUR  = -5'sd4;
  localparam logic signed [DE_W-1:0] DE_NEG_EIGHT = -5'sd8;

  // magnetization step for one spin change
  localparam logic signed [MAG_W-1:0] MAG_STEP = 12'sd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;  // write one all-up row of the clearing pass
    logic take;      // register the accepted input beat
    logic rd_first;  // read rows r and r-1
    logic capture;   // latch center row, the bits taken from it and the bit above
    logic fire;      // evaluate, write back, load the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last; // clearing pass is on its last row
    logic out_stall;  // output register holds a beat that is not taken
  } sts_t;

endpackage

>>> hdl/ismet_ram.sv
// generic simple ram: one write port, two registered read ports
// no dependencies

module ismet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/ismet_ctrl.sv
// sequencing state machine of the spin update core
// depends on ismet_pkg (cmd_t, sts_t)

module ismet_ctrl
  import ismet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EVAL
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (sts.clear_last) state <= S_IDLE;
        S_IDLE:  if (in_tvalid) state <= S_RD1;
        S_RD1:   state <= S_RD2;
        S_RD2:   state <= S_EVAL;
        S_EVAL:  if (!sts.out_stall) state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign in_tready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clear_wr = (state == S_CLEAR);
    cmd.take     = (state == S_IDLE) && in_tvalid;
    cmd.rd_first = (state == S_RD1);
    cmd.capture  = (state == S_RD2);
    cmd.fire     = (state == S_EVAL) && !sts.out_stall;
  end

`ifndef SYNTH
  // never overwrite a result the sink has not taken
  a_fire_no_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> !sts.out_stall)
    else $error("evaluation fired over a stalled output beat");
`endif

endmodule

>>> hdl/ismet_dpath.sv
// datapath of the spin update core: lattice row store, neighbour fetch,
// energy and acceptance logic, magnetization, thresholds, output register
// depends on ismet_pkg and ismet_ram

module ismet_dpath
  import ismet_pkg::*;
#(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_col,
  input  logic                    in_spin_value,
  input  logic [RND_W-1:0]        in_random_fraction,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [THR_W-1:0]        cfg_data,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic                    out_flipped,
  output logic signed [DE_W-1:0]  out_de,
  output logic signed [MAG_W-1:0] out_mag
);

  localparam int RW    = $clog2(SIDE);
  localparam int MW    = (RW + 1 > ROW_W) ? RW + 1 : ROW_W;
  localparam int SUB_N = ((2 ** ROW_W) - 1) / SIDE;
  localparam logic [RW-1:0] IDX_LAST = RW'(SIDE - 1);
  localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(SIDE * SIDE);

  // fold an incoming 5-bit index onto the lattice edge
  function automatic logic [RW-1:0] wrap_idx(input logic [ROW_W-1:0] v);
    logic [MW-1:0] t;
    t = MW'(v);
    for (int i = 0; i < SUB_N; i++) begin
      if (t >= MW'(SIDE)) t = t - MW'(SIDE);
    end
    return RW'(t);
  endfunction

  // item registers
  logic [KIND_W-1:0] kind_q;
  logic              sv_q;
  logic [RND_W-1:0]  rnd_q;
  logic [RW-1:0]     r_q, c_q;
  logic [RW-1:0]     rm, rp, cm, cp;

  // fetched spins
  logic [SIDE-1:0]   row_word;
  logic              s_q, left_q, right_q, up_q;

  // config and state
  logic [THR_W-1:0]        thr_four, thr_eight;
  logic signed [MAG_W-1:0] mag, mag_next;
  logic [RW-1:0]           clr_cnt;

  // ram ports
  logic            ram_we;
  logic [RW-1:0]   ram_waddr, ram_raddr_a;
  logic [SIDE-1:0] ram_wdata, rdata_a, rdata_b;

  // evaluation
  logic                   down;
  logic [2:0]             up_cnt;
  logic signed [5:0]      de_pos, de_neg;
  logic signed [DE_W-1:0] de;
  logic                   accept, changed, new_bit;
  logic [SIDE-1:0]        new_row;

  assign rm = (r_q == '0) ? IDX_LAST : r_q - RW'(1);
  assign rp = (r_q == IDX_LAST) ? '0 : r_q + RW'(1);
  assign cm = (c_q == '0) ? IDX_LAST : c_q - RW'(1);
  assign cp = (c_q == IDX_LAST) ? '0 : c_q + RW'(1);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q <= in_kind;
      sv_q   <= in_spin_value;
      rnd_q  <= in_random_fraction;
      r_q    <= wrap_idx(in_row);
      c_q    <= wrap_idx(in_col);
    end
    if (cmd.capture) begin
      row_word <= rdata_a;
      s_q      <= rdata_a[c_q];
      left_q   <= rdata_a[cm];
      right_q  <= rdata_a[cp];
      up_q     <= rdata_b[c_q];
    end
  end

  // rows r and r-1 first, then row r+1 held through evaluation
  assign ram_raddr_a = cmd.rd_first ? r_q : rp;

  ismet_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (rm),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // energy: dE = 2*s*(2k-4), k the count of up neighbours
  always_comb begin
    down   = rdata_a[c_q];
    up_cnt = 3'(left_q) + 3'(right_q) + 3'(up_q) + 3'(down);
    de_pos = $signed({1'b0, up_cnt, 2'b00}) - 6'sd8;
    de_neg = -de_pos;
    de     = s_q ? de_pos[DE_W-1:0] : de_neg[DE_W-1:0];

    if (de <= DE_ZERO)      accept = 1'b1;
    else if (de == DE_FOUR) accept = rnd_q < thr_four;
    else                    accept = rnd_q < thr_eight;

    if (kind_q == KIND_TRIAL) begin
      changed = accept;
      new_bit = ~s_q;
    end else begin
      changed = (sv_q != s_q);
      new_bit = sv_q;
    end

    new_row       = row_word;
    new_row[c_q]  = new_bit;

    if (!changed)     mag_next = mag;
    else if (new_bit) mag_next = mag + MAG_STEP;
    else              mag_next = mag - MAG_STEP;
  end

  always_comb begin
    ram_we    = cmd.clear_wr || (cmd.fire && changed);
    ram_waddr = cmd.clear_wr ? clr_cnt : r_q;
    ram_wdata = cmd.clear_wr ? '1 : new_row;
  end

  assign sts.clear_last = (clr_cnt == IDX_LAST);
  assign sts.out_stall  = out_tvalid && !out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      mag        <= MAG_RESET;
      thr_four   <= '0;
      thr_eight  <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_cnt <= clr_cnt + RW'(1);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THR_FOUR:  thr_four  <= cfg_data;
          CFG_THR_EIGHT: thr_eight <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.fire) begin
        mag        <= mag_next;
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_flipped <= (kind_q == KIND_TRIAL) && accept;
      out_de      <= (kind_q == KIND_TRIAL) ? de : DE_ZERO;
      out_mag     <= mag_next;
    end
  end

`ifndef SYNTH
  a_mag_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !cmd.fire |=> $stable(mag))
    else $error("magnetization moved without an evaluation");
  a_de_legal: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> (out_de == DE_ZERO || out_de == DE_FOUR || out_de == DE_EIGHT ||
                    out_de == DE_NEG_FOUR || out_de == DE_NEG_EIGHT))
    else $error("energy change outside the lattice set");
  a_neg_de_flips: assert property (@(posedge clk) disable iff (rst)
    (out_tvalid && out_de < DE_ZERO) |-> out_flipped)
    else $error("downhill trial was not flipped");
`endif

endmodule

>>> hdl/ising_metropolis_spin_update_core.sv
// top level of the ising metropolis spin update core
// depends on ismet_pkg, ismet_ctrl, ismet_dpath (and through it ismet_ram)
//
// channel   direction  handshake            payload
// in        sink       in_tvalid/in_tready  in_tuser kind, in_tdata row/col/spin/random
// out       source     out_tvalid/out_tready out_tdata flipped/energy/magnetization
// cfg       sink       cfg_we               cfg_index, cfg_data (threshold)
//
// each item passes through accept, read rows r and r-1, read row r+1,
// then evaluate and write row r back if the spin changed; the single row
// store with two read ports sets this sequence; no new item is taken before it ends
// after reset a clearing pass writes all spins up, one row a cycle over all
// SIDE rows, with in_tready low; configuration writes are taken throughout
// a held output beat keeps the core in evaluation, so in_tready stays low
// until the sink takes the beat

module ising_metropolis_spin_update_core
  import ismet_pkg::*;
#(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row[4:0], col[9:5], spin_value[10],
                                            // random_fraction[26:11], zero pad
  input  logic [KIND_W-1:0]     in_tuser,   // kind[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // flipped[0], energy_change[5:1],
                                            // magnetization[17:6], zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [THR_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  logic                    out_flipped;
  logic signed [DE_W-1:0]  out_de;
  logic signed [MAG_W-1:0] out_mag;

  // sequencer: clearing pass, item phases, output stall
  ismet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // field unpacking straight off the input beat
  ismet_dpath #(
    .SIDE (SIDE)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_tuser),
    .in_row             (in_tdata[ROW_W-1:0]),
    .in_col             (in_tdata[ROW_W+COL_W-1:ROW_W]),
    .in_spin_value      (in_tdata[ROW_W+COL_W]),
    .in_random_fraction (in_tdata[ROW_W+COL_W+RND_W:ROW_W+COL_W+1]),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_flipped        (out_flipped),
    .out_de             (out_de),
    .out_mag            (out_mag)
  );

  // result beat packing, lowest field first
  assign out_tdata = {(OUT_DATA_W - 1 - DE_W - MAG_W)'(0), out_mag, out_de, out_flipped};

endmodule

>>> dv/tb_ising_metropolis_spin_update_core.sv
// self-checking testbench for ising_metropolis_spin_update_core
// keeps its own lattice and magnetization copy and scores every result beat
// depends on ismet_pkg and the core rtl under hdl

module tb_ising_metropolis_spin_update_core
  import ismet_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE        = SIDE_DEFAULT;
  localparam int CELLS       = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 16;   // idle wait past the last result before the next phase
  localparam int HOLD_AT     = 400;  // input beat count that starts the long receiver stall
  localparam int HOLD_LEN    = 300;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              spin;
    logic [RND_W-1:0]  rnd;
  } site_item_t;

  typedef struct {
    logic                    flipped;
    logic signed [DE_W-1:0]  de;
    logic signed [MAG_W-1:0] mag;
  } spin_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // row, col, spin_value, random_fraction, pad
  logic [KIND_W-1:0]     in_tuser = KIND_LOAD;  // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // flipped, energy_change, magnetization, pad
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_THR_FOUR;
  logic [THR_W-1:0]      cfg_data = '0;

  ising_metropolis_spin_update_core #(.SIDE(SIDE)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // stimulus and scoreboard state
  site_item_t   site_items_q[$];
  spin_result_t spin_results_q[$];
  int           n_queued = 0;
  int           n_results = 0;
  int           n_taken = 0;
  int           err_count = 0;
  int           cycle_count = 0;
  int           in_gap_max = 0;
  int           out_gap_max = 0;

  // predictor state
  bit                lattice [CELLS];
  int                mag_total;
  logic [THR_W-1:0]  thr_four;
  logic [THR_W-1:0]  thr_eight;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic int spin_of(int r, int c);
    return lattice[r * SIDE + c] ? 1 : -1;
  endfunction

  // one lattice update: a load writes the spin, a trial applies the metropolis rule
  function automatic spin_result_t apply_spin_item(site_item_t it);
    spin_result_t res;
    int r, c, s, nsum, de;
    bit accept;
    r = int'(it.row) % SIDE;
    c = int'(it.col) % SIDE;
    s = spin_of(r, c);
    res.flipped = 1'b0;
    res.de = DE_ZERO;
    if (it.kind == KIND_LOAD) begin
      mag_total += (it.spin ? 1 : -1) - s;
      lattice[r * SIDE + c] = it.spin;
    end else begin
      // periodic neighbours
      nsum = spin_of(r, (c + SIDE - 1) % SIDE) + spin_of(r, (c + 1) % SIDE)
           + spin_of((r + SIDE - 1) % SIDE, c) + spin_of((r + 1) % SIDE, c);
      de = 2 * s * nsum;
      res.de = DE_W'(de);
      if (res.de <= DE_ZERO) accept = 1'b1;
      else if (res.de == DE_FOUR) accept = it.rnd < thr_four;
      else accept = it.rnd < thr_eight;
      if (accept) begin
        res.flipped = 1'b1;
        lattice[r * SIDE + c] = (s < 0);
        mag_total -= 2 * s;
      end
    end
    res.mag = MAG_W'(mag_total);
    return res;
  endfunction

  // driver: offers queued items, idle gap drawn per item
  int in_gap_left = 0;
  always @(posedge clk) begin
    site_item_t it;
    if (rst) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (site_items_q.size() > 0) begin
        it = site_items_q.pop_front();
        in_tuser  <= it.kind;
        in_tdata  <= IN_DATA_W'({it.rnd, it.spin, it.col, it.row});
        in_tvalid <= 1'b1;
        in_gap_left = $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver stall, once, so the core backs up into its input
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_taken == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: stall drawn after every result beat
  int out_wait = 0;
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_tready <= 1'b0;
      out_wait <= 0;
    end else begin
      w = out_wait;
      if (out_tvalid && out_tready) w = $urandom_range(0, out_gap_max);
      else if (w > 0) w--;
      out_wait <= w;
      out_tready <= (w == 0) && (hold_left == 0);
    end
  end

  // monitor: predicts on every input beat, scores every result beat
  always @(posedge clk) begin
    site_item_t   it;
    spin_result_t exp_r, got_r;
    if (rst) begin
      foreach (lattice[i]) lattice[i] = 1'b1;
      mag_total = CELLS;
      thr_four = '0;
      thr_eight = '0;
      spin_results_q.delete();
      n_results <= 0;
      n_taken <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THR_FOUR:  thr_four = cfg_data;
          CFG_THR_EIGHT: thr_eight = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        it.kind = in_tuser;
        it.row  = in_tdata[4:0];
        it.col  = in_tdata[9:5];
        it.spin = in_tdata[10];
        it.rnd  = in_tdata[26:11];
        spin_results_q.insert(spin_results_q.size(), apply_spin_item(it));
        n_taken <= n_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        if (spin_results_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", out_tdata));
        end else begin
          exp_r = spin_results_q.pop_front();
          got_r.flipped = out_tdata[0];
          got_r.de      = out_tdata[5:1];
          got_r.mag     = out_tdata[17:6];
          if (got_r.flipped !== exp_r.flipped)
            report_mismatch($sformatf("beat %0d flipped %b want %b",
                                      n_results, got_r.flipped, exp_r.flipped));
          if (got_r.de !== exp_r.de)
            report_mismatch($sformatf("beat %0d energy_change %0d want %0d",
                                      n_results, got_r.de, exp_r.de));
          if (got_r.mag !== exp_r.mag)
            report_mismatch($sformatf("beat %0d magnetization %0d want %0d",
                                      n_results, got_r.mag, exp_r.mag));
        end
        n_results <= n_results + 1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_item(input logic [KIND_W-1:0] kind, input int row, input int col,
                            input logic spin, input int rnd);
    site_item_t it;
    it.kind = kind;
    it.row  = ROW_W'(row);
    it.col  = COL_W'(col);
    it.spin = spin;
    it.rnd  = RND_W'(rnd);
    site_items_q.insert(site_items_q.size(), it);
    n_queued++;
  endtask

  // random traffic, mostly trials; half the sites sit around the wrap corner
  // so neighbourhoods get mixed, some fractions land right on a threshold
  task automatic queue_random(input int n, input logic [THR_W-1:0] t4,
                              input logic [THR_W-1:0] t8);
    site_item_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      it.kind = ($urandom_range(0, 9) < 7) ? KIND_TRIAL : KIND_LOAD;
      if ($urandom_range(0, 1)) begin
        it.row = ROW_W'($urandom);
        it.col = COL_W'($urandom);
      end else begin
        it.row = ROW_W'(30 + $urandom_range(0, 3));
        it.col = COL_W'(30 + $urandom_range(0, 3));
      end
      it.spin = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 7);
      case (pick)
        0: it.rnd = t4;
        1: it.rnd = t4 - 1'b1;
        2: it.rnd = t8;
        3: it.rnd = t8 - 1'b1;
        default: it.rnd = RND_W'($urandom);
      endcase
      site_items_q.insert(site_items_q.size(), it);
      n_queued++;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (n_results != n_queued) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [THR_W-1:0] t4, input logic [THR_W-1:0] t8);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THR_FOUR;
    cfg_data  <= t4;
    @(posedge clk);
    cfg_index <= CFG_THR_EIGHT;
    cfg_data  <= t8;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [THR_W-1:0] t4, t8;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, thresholds at reset value zero
    @(negedge clk);
    in_gap_max = 3;
    out_gap_max = 3;
    queue_item(KIND_TRIAL, 0, 0, 1'b0, 0);          // all up: energy 8, zero threshold holds
    queue_item(KIND_TRIAL, 31, 31, 1'b1, 16'hFFFF);
    queue_item(KIND_LOAD, 0, 0, 1'b0, 16'hFFFF);     // spin down
    queue_item(KIND_LOAD, 0, 0, 1'b0, 0);            // same value again
    queue_item(KIND_TRIAL, 0, 0, 1'b0, 16'hFFFF);    // energy -8 flips
    queue_item(KIND_LOAD, 0, 1, 1'b0, 0);
    queue_item(KIND_LOAD, 1, 0, 1'b0, 0);
    queue_item(KIND_TRIAL, 0, 0, 1'b1, 16'h1234);    // energy 0 flips
    queue_item(KIND_TRIAL, 0, 0, 1'b0, 0);           // and back
    queue_item(KIND_LOAD, 0, 31, 1'b0, 0);           // wrapped column neighbour
    queue_item(KIND_TRIAL, 0, 0, 1'b1, 16'hFFFF);    // energy -4 flips
    queue_item(KIND_TRIAL, 0, 0, 1'b0, 0);           // energy 4, zero threshold holds
    wait_drained();

    // directed, strict compare at the top and bottom of the fraction range
    write_thresholds(16'hFFFF, 16'h0001);
    @(negedge clk);
    queue_item(KIND_TRIAL, 0, 0, 1'b0, 16'hFFFF);    // equal to threshold, holds
    queue_item(KIND_TRIAL, 0, 0, 1'b1, 16'hFFFE);    // just below, flips
    queue_item(KIND_TRIAL, 16, 16, 1'b0, 1);         // energy 8, equal, holds
    queue_item(KIND_TRIAL, 16, 16, 1'b0, 0);         // energy 8, below, flips
    queue_item(KIND_LOAD, 16, 16, 1'b1, 16'hFFFF);
    queue_item(KIND_LOAD, 31, 0, 1'b1, 16'hFFFF);
    queue_item(KIND_TRIAL, 31, 0, 1'b1, 16'hAAAA);
    queue_item(KIND_TRIAL, 0, 31, 1'b0, 16'h5555);
    wait_drained();

    // random phases over several threshold and pacing settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin t4 = 16'h0000; t8 = 16'h0000; in_gap_max = 0;  out_gap_max = 0;  end
        1: begin t4 = 16'hFFFF; t8 = 16'hFFFF; in_gap_max = 19; out_gap_max = 19; end
        2: begin t4 = RND_W'($urandom); t8 = RND_W'($urandom);
                 in_gap_max = 0;  out_gap_max = 19; end
        3: begin t4 = 16'h8000; t8 = 16'h1000; in_gap_max = 19; out_gap_max = 0;  end
        default: begin t4 = 16'h0001; t8 = 16'hFFFF; in_gap_max = 5; out_gap_max = 5; end
      endcase
      write_thresholds(t4, t8);
      @(negedge clk);
      queue_random(200, t4, t8);
      wait_drained();
    end

    if (spin_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", spin_results_q.size()));
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/ismet_pkg.sv
hdl/ismet_ram.sv
hdl/ismet_ctrl.sv
hdl/ismet_dpath.sv
hdl/ising_metropolis_spin_update_core.sv
dv/tb_ising_metropolis_spin_update_core.sv
